// File: design/bary_pkg.sv
// shared types, constants and helpers for the barycentric coordinate pipeline
`default_nettype none
package bary_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int WEIGHT_FRAC_BITS = 24;
    localparam int WEIGHT_WIDTH     = 32;
    localparam int QUOT_BITS        = WEIGHT_WIDTH - 1;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic sat_a;
        logic sat_b;
        logic degen;
    } div_flags_t;

    // cyclic successor of an axis
    function automatic axis_t next_axis(input axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/bary_axis.sv
// triangle normal, dominant axis and first projection axis (X in planar mode), five register stages
`default_nettype none
module bary_axis #(
    parameter int CW = bary_pkg::COORD_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    planar_mode,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [3:0][2:0][CW-1:0] in_pts,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [3:0][2:0][CW-1:0]      out_pts,
    output bary_pkg::axis_t              out_ax0
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int NS = 5;

    logic                           en;
    logic [NS-1:0]                  vld_reg;
    logic [NS-1:0][3:0][2:0][CW-1:0] pts_reg;
    logic [NS-2:0]                  planar_reg;
    logic signed [DW-1:0]           e_reg [3];
    logic signed [DW-1:0]           f_reg [3];
    logic signed [PW-1:0]           m_reg [6];
    logic signed [NW-1:0]           n_reg [3];
    logic [NW-1:0]                  mag_reg [3];
    bary_pkg::axis_t                ax_reg;
    bary_pkg::axis_t                ax_next;
    bary_pkg::axis_t                lng;
    logic [NW-1:0]                  best;

    assign en        = !vld_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];
    assign out_pts   = pts_reg[NS-1];
    assign out_ax0   = ax_reg;

    function automatic logic signed [DW-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    // lowest axis wins a tie
    always_comb begin
        lng  = bary_pkg::AXIS_X;
        best = mag_reg[0];
        if (mag_reg[1] > best) begin
            lng  = bary_pkg::AXIS_Y;
            best = mag_reg[1];
        end
        if (mag_reg[2] > best) begin
            lng = bary_pkg::AXIS_Z;
        end
        ax_next = planar_reg[NS-2] ? bary_pkg::AXIS_X : bary_pkg::next_axis(lng);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pts_reg[0] <= in_pts;
            for (int i = 1; i < NS; i++) begin
                pts_reg[i] <= pts_reg[i-1];
            end
            planar_reg <= {planar_reg[NS-3:0], planar_mode};
            for (int k = 0; k < 3; k++) begin
                e_reg[k]   <= dif(in_pts[3][k], in_pts[1][k]);
                f_reg[k]   <= dif(in_pts[2][k], in_pts[1][k]);
                n_reg[k]   <= NW'(m_reg[2*k]) - NW'(m_reg[2*k+1]);
                mag_reg[k] <= n_reg[k][NW-1] ? NW'(-n_reg[k]) : NW'(n_reg[k]);
            end
            m_reg[0] <= e_reg[1] * f_reg[2];
            m_reg[1] <= e_reg[2] * f_reg[1];
            m_reg[2] <= e_reg[2] * f_reg[0];
            m_reg[3] <= e_reg[0] * f_reg[2];
            m_reg[4] <= e_reg[0] * f_reg[1];
            m_reg[5] <= e_reg[1] * f_reg[0];
            ax_reg   <= ax_next;
        end
    end

endmodule
`default_nettype wire

// File: design/bary_proj.sv
// projection onto two axes, determinant and numerators, three register stages
`default_nettype none
module bary_proj #(
    parameter int CW = bary_pkg::COORD_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [3:0][2:0][CW-1:0] in_pts,
    input  wire bary_pkg::axis_t         in_ax0,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [2*CW+2:0]       out_det,
    output logic signed [2*CW+2:0]       out_num_a,
    output logic signed [2*CW+2:0]       out_num_b
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int NS = 3;

    logic                 en;
    logic [NS-1:0]        vld_reg;
    bary_pkg::axis_t      ax1;
    logic signed [DW-1:0] t11_reg, t12_reg, t21_reg, t22_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] pd_reg [6];
    logic signed [NW-1:0] det_reg, num_a_reg, num_b_reg;

    assign en        = !vld_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];
    assign out_det   = det_reg;
    assign out_num_a = num_a_reg;
    assign out_num_b = num_b_reg;
    assign ax1       = bary_pkg::next_axis(in_ax0);

    function automatic logic signed [DW-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t11_reg   <= dif(in_pts[1][in_ax0], in_pts[3][in_ax0]);
            t12_reg   <= dif(in_pts[2][in_ax0], in_pts[3][in_ax0]);
            t21_reg   <= dif(in_pts[1][ax1], in_pts[3][ax1]);
            t22_reg   <= dif(in_pts[2][ax1], in_pts[3][ax1]);
            dx_reg    <= dif(in_pts[0][in_ax0], in_pts[3][in_ax0]);
            dy_reg    <= dif(in_pts[0][ax1], in_pts[3][ax1]);
            pd_reg[0] <= t11_reg * t22_reg;
            pd_reg[1] <= t12_reg * t21_reg;
            pd_reg[2] <= t22_reg * dx_reg;
            pd_reg[3] <= t12_reg * dy_reg;
            pd_reg[4] <= t11_reg * dy_reg;
            pd_reg[5] <= t21_reg * dx_reg;
            det_reg   <= NW'(pd_reg[0]) - NW'(pd_reg[1]);
            num_a_reg <= NW'(pd_reg[2]) - NW'(pd_reg[3]);
            num_b_reg <= NW'(pd_reg[4]) - NW'(pd_reg[5]);
        end
    end

endmodule
`default_nettype wire

// File: design/bary_div.sv
// pipelined restoring divider for both weights, one quotient bit per stage
`default_nettype none
module bary_div #(
    parameter int NW = 2 * bary_pkg::COORD_WIDTH + 3,
    parameter int F  = bary_pkg::WEIGHT_FRAC_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [NW-1:0]           in_det,
    input  wire logic signed [NW-1:0]           in_num_a,
    input  wire logic signed [NW-1:0]           in_num_b,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bary_pkg::QUOT_BITS-1:0]      out_q_a,
    output logic [bary_pkg::QUOT_BITS-1:0]      out_q_b,
    output bary_pkg::div_flags_t                out_flags
);
    localparam int Q  = bary_pkg::QUOT_BITS;
    localparam int RW = NW + Q;
    localparam int NS = Q + 2;

    logic                 en;
    logic [NS-1:0]        vld_reg;
    logic [NW-1:0]        a_mag_reg, b_mag_reg, d_mag_reg;
    logic                 neg_a_reg, neg_b_reg, degen_reg;
    logic [RW-1:0]        rem_a_reg [Q+1];
    logic [RW-1:0]        rem_b_reg [Q+1];
    logic [NW-1:0]        d_reg     [Q+1];
    logic [Q-1:0]         q_a_reg   [Q+1];
    logic [Q-1:0]         q_b_reg   [Q+1];
    bary_pkg::div_flags_t flags_reg [Q+1];

    assign en        = !vld_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];
    assign out_q_a   = q_a_reg[Q];
    assign out_q_b   = q_b_reg[Q];
    assign out_flags = flags_reg[Q];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // magnitudes and signs, then overflow test and remainder seed
    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg <= in_num_a[NW-1] ? NW'(-in_num_a) : NW'(in_num_a);
            b_mag_reg <= in_num_b[NW-1] ? NW'(-in_num_b) : NW'(in_num_b);
            d_mag_reg <= in_det[NW-1] ? NW'(-in_det) : NW'(in_det);
            neg_a_reg <= in_num_a[NW-1] ^ in_det[NW-1];
            neg_b_reg <= in_num_b[NW-1] ^ in_det[NW-1];
            degen_reg <= (in_det == '0);

            rem_a_reg[0]       <= RW'(a_mag_reg) << F;
            rem_b_reg[0]       <= RW'(b_mag_reg) << F;
            d_reg[0]           <= d_mag_reg;
            q_a_reg[0]         <= '0;
            q_b_reg[0]         <= '0;
            flags_reg[0].neg_a <= neg_a_reg;
            flags_reg[0].neg_b <= neg_b_reg;
            flags_reg[0].sat_a <= RW'(a_mag_reg) >= (RW'(d_mag_reg) << (Q - F));
            flags_reg[0].sat_b <= RW'(b_mag_reg) >= (RW'(d_mag_reg) << (Q - F));
            flags_reg[0].degen <= degen_reg;
        end
    end

    for (genvar j = 0; j < Q; j++) begin : g_step
        localparam int SH = Q - 1 - j;
        logic [RW-1:0] dsh;
        logic          ge_a, ge_b;

        assign dsh  = RW'(d_reg[j]) << SH;
        assign ge_a = rem_a_reg[j] >= dsh;
        assign ge_b = rem_b_reg[j] >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[j+1] <= ge_a ? rem_a_reg[j] - dsh : rem_a_reg[j];
                rem_b_reg[j+1] <= ge_b ? rem_b_reg[j] - dsh : rem_b_reg[j];
                q_a_reg[j+1]   <= q_a_reg[j] | (Q'(ge_a) << SH);
                q_b_reg[j+1]   <= q_b_reg[j] | (Q'(ge_b) << SH);
                d_reg[j+1]     <= d_reg[j];
                flags_reg[j+1] <= flags_reg[j];
            end
        end
    end

endmodule
`default_nettype wire

// File: design/triangle_barycentric_coords.sv
// a request passes the axis, projection and divider sections, then the output stage, to the m_ side
// one request per cycle unless stalled; the 33-stage divider (31 quotient bits) sets the depth
// stalls freeze each pipeline section whose last stage holds a request; nothing is dropped
// reset: synchronous active-low aresetn clears all valid bits and planar_mode to 0
// top level: config register, pipeline sections and the weight output stage
`default_nettype none
module triangle_barycentric_coords #(
    parameter int COORD_WIDTH      = bary_pkg::COORD_WIDTH,
    parameter int WEIGHT_FRAC_BITS = bary_pkg::WEIGHT_FRAC_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic                                 cfg_wr_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z, zero pad
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // weight_a, weight_b, weight_c
    output logic [3*bary_pkg::WEIGHT_WIDTH-1:0]       m_axis_tdata,
    // degenerate
    output logic                                      m_axis_tuser
);
    localparam int CW = COORD_WIDTH;
    localparam int NW = 2 * (CW + 1) + 1;
    localparam int Q  = bary_pkg::QUOT_BITS;
    localparam int WW = bary_pkg::WEIGHT_WIDTH;
    localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};
    localparam logic signed [WW+1:0] W_ONE = (WW+2)'(2**WEIGHT_FRAC_BITS);

    logic                    planar_mode_reg;
    logic [3:0][2:0][CW-1:0] in_pts, ax_pts;
    logic                    ax_valid, ax_ready;
    bary_pkg::axis_t         ax0;
    logic                    pj_valid, pj_ready;
    logic signed [NW-1:0]    det, num_a, num_b;
    logic                    dv_valid, dv_ready;
    logic [Q-1:0]            q_a, q_b;
    bary_pkg::div_flags_t    flags;

    logic                    en;
    logic [1:0]              vld_reg;
    logic signed [WW-1:0]    wa_reg, wb_reg, wa_out_reg, wb_out_reg, wc_reg;
    logic                    degen_reg, degen_out_reg;
    logic signed [WW+1:0]    wc_sum;
    logic signed [WW-1:0]    wc_next;

    assign in_pts = s_axis_tdata[12*CW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planar_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            planar_mode_reg <= cfg_wr_data;
        end
    end

    bary_axis #(.CW(CW)) u_axis (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .planar_mode (planar_mode_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_pts      (in_pts),
        .out_valid   (ax_valid),
        .out_ready   (ax_ready),
        .out_pts     (ax_pts),
        .out_ax0     (ax0)
    );

    bary_proj #(.CW(CW)) u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ax_valid),
        .in_ready  (ax_ready),
        .in_pts    (ax_pts),
        .in_ax0    (ax0),
        .out_valid (pj_valid),
        .out_ready (pj_ready),
        .out_det   (det),
        .out_num_a (num_a),
        .out_num_b (num_b)
    );

    bary_div #(.NW(NW), .F(WEIGHT_FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pj_valid),
        .in_ready  (pj_ready),
        .in_det    (det),
        .in_num_a  (num_a),
        .in_num_b  (num_b),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_q_a   (q_a),
        .out_q_b   (q_b),
        .out_flags (flags)
    );

    function automatic logic signed [WW-1:0] weight(input logic [Q-1:0] q, input logic neg,
                                                    input logic sat, input logic degen);
        logic signed [WW-1:0] w;
        if (degen) begin
            w = '0;
        end else if (sat) begin
            w = neg ? W_MIN : W_MAX;
        end else begin
            w = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
        return w;
    endfunction

    // weight_c = 1 - weight_a - weight_b, saturated; forced to zero when degenerate
    always_comb begin
        wc_sum = W_ONE - (WW+2)'(wa_reg) - (WW+2)'(wb_reg);
        if (degen_reg) begin
            wc_next = '0;
        end else if (wc_sum[WW+1:WW-1] == 3'b000 || wc_sum[WW+1:WW-1] == 3'b111) begin
            wc_next = wc_sum[WW-1:0];
        end else begin
            wc_next = wc_sum[WW+1] ? W_MIN : W_MAX;
        end
    end

    assign en            = !vld_reg[1] || m_axis_tready;
    assign dv_ready      = en;
    assign m_axis_tvalid = vld_reg[1];
    assign m_axis_tdata  = {wc_reg, wb_out_reg, wa_out_reg};
    assign m_axis_tuser  = degen_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], dv_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wa_reg        <= weight(q_a, flags.neg_a, flags.sat_a, flags.degen);
            wb_reg        <= weight(q_b, flags.neg_b, flags.sat_b, flags.degen);
            degen_reg     <= flags.degen;
            wa_out_reg    <= wa_reg;
            wb_out_reg    <= wb_reg;
            wc_reg        <= wc_next;
            degen_out_reg <= degen_reg;
        end
    end

endmodule
`default_nettype wire
